>>> rtl/core/ddd_pkg.sv
// shared types, constants and calendar tables for the date difference block
// no dependencies
package ddd_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 22;
	// day number of any 14-bit year fits in 23 bits
	localparam int DN_W   = 23;
	localparam int PROD_W = 27;
	localparam int CENT_W = 8;
	localparam int OFF_W  = 10;
	localparam int YCMP_W = 16;

	localparam int MAX_YEAR_DEF = 9999;

	// floor(x / 100) = (x * 5243) >> 19 for x below 16384
	localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);
	localparam int                RECIP_SH  = 19;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [MON_W-1:0] MON_FEB   = MON_W'(2);
	localparam logic [MON_W-1:0] MON_DEC   = MON_W'(12);

	typedef struct packed {
		logic [DAY_W-1:0]  start_day;
		logic [MON_W-1:0]  start_month;
		logic [YEAR_W-1:0] start_year;
		logic [DAY_W-1:0]  end_day;
		logic [MON_W-1:0]  end_month;
		logic [YEAR_W-1:0] end_year;
		logic              include_end;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] day_count;
		logic             invalid_date;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MULP,
		OP_MULY,
		OP_LEAP,
		OP_SUM1,
		OP_SUM2,
		OP_DIFF,
		OP_FINAL
	} op_t;

	typedef struct packed {
		logic load;
		logic sel;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	// length of a month in a common year, zero for a bad month code
	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    r = DAY_W'(30);
			4'd2:                                       r = DAY_W'(28);
			default:                                    r = '0;
		endcase
		return r;
	endfunction

	// days before the first of month m in a common year
	function automatic logic [OFF_W-1:0] month_start(input logic [MON_W-1:0] m);
		logic [OFF_W-1:0] r;
		case (m)
			4'd2:    r = OFF_W'(31);
			4'd3:    r = OFF_W'(59);
			4'd4:    r = OFF_W'(90);
			4'd5:    r = OFF_W'(120);
			4'd6:    r = OFF_W'(151);
			4'd7:    r = OFF_W'(181);
			4'd8:    r = OFF_W'(212);
			4'd9:    r = OFF_W'(243);
			4'd10:   r = OFF_W'(273);
			4'd11:   r = OFF_W'(304);
			4'd12:   r = OFF_W'(334);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/ddd_ctrl.sv
// sequencer for the date difference block: walks both dates through the datapath
// depends on ddd_pkg
module ddd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ddd_pkg::sts_t sts,
	output ddd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULP,
		S_MULY,
		S_LEAP,
		S_SUM1,
		S_SUM2,
		S_DIFF,
		S_FINAL
	} state_t;

	state_t state_q;
	logic   sel_q;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.load = req_valid && (state_q == S_IDLE);
		cmd.sel  = sel_q;
		unique case (state_q)
			S_IDLE:  cmd.op = ddd_pkg::OP_NONE;
			S_MULP:  cmd.op = ddd_pkg::OP_MULP;
			S_MULY:  cmd.op = ddd_pkg::OP_MULY;
			S_LEAP:  cmd.op = ddd_pkg::OP_LEAP;
			S_SUM1:  cmd.op = ddd_pkg::OP_SUM1;
			S_SUM2:  cmd.op = ddd_pkg::OP_SUM2;
			S_DIFF:  cmd.op = ddd_pkg::OP_DIFF;
			S_FINAL: cmd.op = sts.out_busy ? ddd_pkg::OP_NONE : ddd_pkg::OP_FINAL;
			default: cmd.op = ddd_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_MULP;
						sel_q   <= 1'b0;
					end
				end
				S_MULP: state_q <= S_MULY;
				S_MULY: state_q <= S_LEAP;
				S_LEAP: state_q <= S_SUM1;
				S_SUM1: state_q <= S_SUM2;
				S_SUM2: begin
					if (sel_q) begin
						state_q <= S_DIFF;
					end else begin
						sel_q   <= 1'b1;
						state_q <= S_MULP;
					end
				end
				S_DIFF: state_q <= S_FINAL;
				S_FINAL: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// second date done leads straight to the difference step
	a_sum2_to_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM2 && sel_q) |=> (state_q == S_DIFF))
		else $error("end date finished without difference step");

	// a transfer always starts on the start date
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_MULP && !sel_q))
		else $error("new item did not start on start date");

	// no result is issued while the output register still holds one
	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ddd_pkg::OP_FINAL) |-> !sts.out_busy)
		else $error("result issued into a busy output register");

endmodule

>>> rtl/core/ddd_dpath.sv
// datapath for the date difference block: day numbers, validity, count, output register
// depends on ddd_pkg
module ddd_dpath #(
	parameter int MAX_YEAR = ddd_pkg::MAX_YEAR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ddd_pkg::req_t req_data,
	input  ddd_pkg::cmd_t cmd,
	output ddd_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ddd_pkg::rsp_t rsp_data
);

	ddd_pkg::req_t                   req_q;
	logic [ddd_pkg::PROD_W-1:0]      prod_q;
	logic [ddd_pkg::CENT_W-1:0]      cp_q;
	logic                            leap_q;
	logic [ddd_pkg::DN_W-1:0]        acc_q;
	logic [ddd_pkg::DN_W-1:0]        dn_start_q;
	logic [ddd_pkg::DN_W-1:0]        dn_end_q;
	logic                            ok_start_q;
	logic                            ok_end_q;
	logic [ddd_pkg::DN_W-1:0]        diff_q;
	logic                            bad_q;
	ddd_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic [ddd_pkg::DAY_W-1:0]       d;
	logic [ddd_pkg::MON_W-1:0]       m;
	logic [ddd_pkg::YEAR_W-1:0]      y;
	logic [ddd_pkg::YEAR_W-1:0]      p;
	logic [ddd_pkg::CENT_W-1:0]      cy;
	logic [ddd_pkg::YEAR_W-1:0]      y_rem;
	logic                            leap;
	logic [ddd_pkg::YEAR_W-3:0]      small_term;
	logic [ddd_pkg::DAY_W-1:0]       mlen;
	logic                            date_ok;
	logic [ddd_pkg::OFF_W-1:0]       day_off;
	logic [ddd_pkg::CNT_W+1:0]       cnt_sum;
	logic [ddd_pkg::CNT_W-1:0]       cnt_sat;

	// selected date fields
	assign d = cmd.sel ? req_q.end_day   : req_q.start_day;
	assign m = cmd.sel ? req_q.end_month : req_q.start_month;
	assign y = cmd.sel ? req_q.end_year  : req_q.start_year;
	assign p = y - ddd_pkg::YEAR_W'(1);

	// leap test from the y/100 product
	assign cy    = prod_q[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SH];
	assign y_rem = y - (ddd_pkg::YEAR_W'(cy) * ddd_pkg::YEAR_W'(100));
	assign leap  = (y[1:0] == 2'b00) && ((y_rem != '0) || (cy[1:0] == 2'b00));

	// p/4 - p/100 + p/400, never negative
	assign small_term = p[ddd_pkg::YEAR_W-1:2] - (ddd_pkg::YEAR_W-2)'(cp_q)
		+ (ddd_pkg::YEAR_W-2)'(cp_q[ddd_pkg::CENT_W-1:2]);

	always_comb begin
		mlen = ddd_pkg::month_len(m);
		if (m == ddd_pkg::MON_FEB && leap_q) begin
			mlen = mlen + ddd_pkg::DAY_W'(1);
		end
	end

	assign date_ok = (y != '0)
		&& (ddd_pkg::YCMP_W'(y) <= ddd_pkg::YCMP_W'(MAX_YEAR))
		&& (m != '0) && (m <= ddd_pkg::MON_DEC)
		&& (d != '0) && (d <= mlen);

	assign day_off = ddd_pkg::month_start(m)
		+ ddd_pkg::OFF_W'(leap_q && (m > ddd_pkg::MON_FEB))
		+ ddd_pkg::OFF_W'(d);

	assign cnt_sum = (ddd_pkg::CNT_W+2)'(diff_q) + (ddd_pkg::CNT_W+2)'(req_q.include_end);
	assign cnt_sat = (cnt_sum > (ddd_pkg::CNT_W+2)'(ddd_pkg::COUNT_MAX))
		? ddd_pkg::COUNT_MAX : cnt_sum[ddd_pkg::CNT_W-1:0];

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_data;
		end
		case (cmd.op)
			ddd_pkg::OP_MULP: begin
				prod_q <= ddd_pkg::PROD_W'(p) * ddd_pkg::RECIP_100;
			end
			ddd_pkg::OP_MULY: begin
				cp_q   <= prod_q[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SH];
				prod_q <= ddd_pkg::PROD_W'(y) * ddd_pkg::RECIP_100;
			end
			ddd_pkg::OP_LEAP: begin
				leap_q <= leap;
				acc_q  <= ddd_pkg::DN_W'(p) * ddd_pkg::DN_W'(365);
			end
			ddd_pkg::OP_SUM1: begin
				acc_q <= acc_q + ddd_pkg::DN_W'(small_term);
			end
			ddd_pkg::OP_SUM2: begin
				if (cmd.sel) begin
					dn_end_q <= acc_q + ddd_pkg::DN_W'(day_off);
					ok_end_q <= date_ok;
				end else begin
					dn_start_q <= acc_q + ddd_pkg::DN_W'(day_off);
					ok_start_q <= date_ok;
				end
			end
			ddd_pkg::OP_DIFF: begin
				diff_q <= (dn_start_q < dn_end_q) ? (dn_end_q - dn_start_q) : '0;
				bad_q  <= !(ok_start_q && ok_end_q);
			end
			ddd_pkg::OP_FINAL: begin
				rsp_q.invalid_date <= bad_q;
				rsp_q.day_count    <= bad_q ? '0 : cnt_sat;
			end
			default: begin
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == ddd_pkg::OP_FINAL) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy = rsp_valid_q && !rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;

	// a bad date never carries a count
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.invalid_date) |-> (rsp_q.day_count == '0))
		else $error("invalid date result with nonzero count");

	// a fresh result appears right after the final step
	a_final_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ddd_pkg::OP_FINAL) |=> rsp_valid_q)
		else $error("final step did not raise result valid");

endmodule

>>> rtl/core/date_difference_in_days.sv
// a new input is taken only in idle, after the sequencer has walked both dates one after
//   the other through five steps of the shared day-number datapath, then the difference
//   and output steps; the output step waits while the output register is still busy
// the next input is taken while a finished result still waits in the output register
// reset: arst_n low clears the sequencer and the result valid; no clearing pass
// depends on ddd_pkg, ddd_ctrl, ddd_dpath
module date_difference_in_days #(
	parameter int MAX_YEAR = ddd_pkg::MAX_YEAR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ddd_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ddd_pkg::rsp_t rsp_data
);

	// command and status between sequencer and datapath
	ddd_pkg::cmd_t cmd;
	ddd_pkg::sts_t sts;

	// sequencer: per date it runs y-1 times 1/100, y times 1/100,
	// leap test with 365*(y-1), century terms, then month offset and day
	ddd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: holds the captured request, both day numbers and the output register
	ddd_dpath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

>>> tb/ddd_span_checker.sv
// checker for the date difference block: watches both channels, predicts each result
// depends on ddd_pkg
module ddd_span_checker #(
	parameter int MAX_YEAR = ddd_pkg::MAX_YEAR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  ddd_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  ddd_pkg::rsp_t rsp_data,
	output int unsigned   mismatches,
	output int unsigned   pending
);

	localparam int unsigned SPAN_LIMIT = (1 << ddd_pkg::CNT_W) - 1;

	ddd_pkg::rsp_t span_queue[$];

	function automatic bit is_leap(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2:                      return is_leap(y) ? 29 : 28;
			4, 6, 9, 11:            return 30;
			1, 3, 5, 7, 8, 10, 12:  return 31;
			default:                return 0;
		endcase
	endfunction

	function automatic bit calendar_valid(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (y < 1 || y > MAX_YEAR)
			return 1'b0;
		return (d >= 1) && (d <= days_in_month(y, m));
	endfunction

	// 0001-01-01 counts as day 1
	function automatic int unsigned serial_day(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned p;
		int unsigned n;
		p = y - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400;
		for (int unsigned i = 1; i < m; i++)
			n += days_in_month(y, i);
		return n + d;
	endfunction

	function automatic ddd_pkg::rsp_t predict_span(input ddd_pkg::req_t q);
		ddd_pkg::rsp_t r;
		int unsigned   a;
		int unsigned   b;
		int unsigned   span;
		r = '0;
		if (!calendar_valid(q.start_day, q.start_month, q.start_year) ||
				!calendar_valid(q.end_day, q.end_month, q.end_year)) begin
			r.invalid_date = 1'b1;
			return r;
		end
		a = serial_day(q.start_day, q.start_month, q.start_year);
		b = serial_day(q.end_day, q.end_month, q.end_year);
		span = (a < b) ? b - a : 0;
		span += q.include_end;
		if (span > SPAN_LIMIT)
			span = SPAN_LIMIT;
		r.day_count = ddd_pkg::CNT_W'(span);
		return r;
	endfunction

	always @(posedge clk) begin
		ddd_pkg::rsp_t want;
		if (!arst_n) begin
			span_queue.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// results first: a query taken at this edge cannot be answered at it
			if (rsp_valid && rsp_ready) begin
				if (span_queue.size() == 0) begin
					$error("result transfer with no query pending: day_count %0d invalid_date %0d",
						rsp_data.day_count, rsp_data.invalid_date);
					mismatches++;
				end else begin
					want = span_queue.pop_front();
					if (rsp_data.day_count !== want.day_count) begin
						$error("day_count: expected %0d, actual %0d",
							want.day_count, rsp_data.day_count);
						mismatches++;
					end
					if (rsp_data.invalid_date !== want.invalid_date) begin
						$error("invalid_date: expected %0d, actual %0d",
							want.invalid_date, rsp_data.invalid_date);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready)
				span_queue.push_back(predict_span(req_data));
			pending = span_queue.size();
		end
	end

endmodule

>>> tb/date_difference_in_days_test.sv
// testbench top for date_difference_in_days: directed and random date queries
// depends on ddd_pkg, ddd_span_checker and the block itself
module date_difference_in_days_test;

	localparam int MAX_YEAR     = ddd_pkg::MAX_YEAR_DEF;
	localparam int RANDOM_ITEMS = 1880;
	// receiver hold-off long enough to back the block up into its input
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 40;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	ddd_pkg::req_t req_data;
	logic          rsp_valid;
	logic          rsp_ready;
	ddd_pkg::rsp_t rsp_data;

	int unsigned   mismatches;
	int unsigned   pending;

	// set near the end: no more idling on either side
	bit            quiet    = 1'b0;
	// counted up by the sender, each step asks the receiver for one long hold-off
	int            hold_req = 0;

	ddd_pkg::req_t directed[$];

	date_difference_in_days #(
		.MAX_YEAR(MAX_YEAR)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	ddd_span_checker #(
		.MAX_YEAR(MAX_YEAR)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	// global time limit, several times the slowest legal run
	initial begin
		#8_000_000;
		$display("FAIL date_difference_in_days");
		$finish;
	end

	function automatic ddd_pkg::req_t query(input int sd, input int sm, input int sy,
			input int ed, input int em, input int ey, input bit inc);
		ddd_pkg::req_t q;
		q.start_day   = ddd_pkg::DAY_W'(sd);
		q.start_month = ddd_pkg::MON_W'(sm);
		q.start_year  = ddd_pkg::YEAR_W'(sy);
		q.end_day     = ddd_pkg::DAY_W'(ed);
		q.end_month   = ddd_pkg::MON_W'(em);
		q.end_year    = ddd_pkg::YEAR_W'(ey);
		q.include_end = inc;
		return q;
	endfunction

	// years weighted toward the ends of the range and toward century years
	function automatic int random_year();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(1, 4);
			1:       return $urandom_range(MAX_YEAR - 3, MAX_YEAR);
			2:       return $urandom_range(1, MAX_YEAR / 100) * 100;
			default: return $urandom_range(1, MAX_YEAR);
		endcase
	endfunction

	// mostly days every month has, sometimes the month-end days that may not exist
	function automatic int random_day();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(29, 31);
		return $urandom_range(1, 28);
	endfunction

	function automatic ddd_pkg::req_t random_query();
		ddd_pkg::req_t q;
		int            pick;
		int            ey;
		pick = $urandom_range(0, 99);
		// raw noise over every bit of every field
		if (pick < 15)
			return ddd_pkg::req_t'(($bits(ddd_pkg::req_t))'({$urandom, $urandom}));
		q = query(random_day(), $urandom_range(1, 12), random_year(), 0, 0, 0,
			1'($urandom_range(0, 1)));
		if (pick < 25) begin
			// same day at both ends
			q.end_day   = q.start_day;
			q.end_month = q.start_month;
			q.end_year  = q.start_year;
		end else begin
			if (pick < 55) begin
				// close dates, small counts, either order
				ey = int'(q.start_year) + int'($urandom_range(0, 4)) - 2;
				if (ey < 1)
					ey = 1;
				if (ey > MAX_YEAR)
					ey = MAX_YEAR;
			end else begin
				ey = random_year();
			end
			q.end_day   = ddd_pkg::DAY_W'(random_day());
			q.end_month = ddd_pkg::MON_W'($urandom_range(1, 12));
			q.end_year  = ddd_pkg::YEAR_W'(ey);
		end
		return q;
	endfunction

	// present one query and hold it until the transfer
	task automatic offer(input ddd_pkg::req_t q);
		bit taken;
		// random idle burst before the item
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_data  <= q;
		req_valid <= 1'b1;
		taken = 1'b0;
		// ready is sampled mid-cycle so the edge decision is race free
		while (!taken) begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end
	endtask

	// stop offering until every predicted result has come back
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// result side: ready high for stretches, low in bursts, one long hold-off on request
	initial begin
		int hold_done;
		hold_done = 0;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != hold_done) begin
				hold_done++;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		req_valid <= 1'b0;
		req_data  <= '0;
		arst_n    <= 1'b0;

		// full range both ways, with and without the end day
		directed.push_back(query(1, 1, 1, 31, 12, 9999, 1));
		directed.push_back(query(1, 1, 1, 31, 12, 9999, 0));
		directed.push_back(query(31, 12, 9999, 1, 1, 1, 0));
		directed.push_back(query(31, 12, 9999, 1, 1, 1, 1));
		// start equal to end
		directed.push_back(query(15, 6, 2024, 15, 6, 2024, 0));
		directed.push_back(query(1, 1, 1, 1, 1, 1, 1));
		// leap rule: every 4, not every 100, again every 400
		directed.push_back(query(28, 2, 2000, 1, 3, 2000, 0));
		directed.push_back(query(29, 2, 400, 1, 3, 400, 1));
		directed.push_back(query(29, 2, 2004, 29, 2, 2008, 1));
		directed.push_back(query(29, 2, 1900, 1, 3, 1900, 0));
		directed.push_back(query(1, 1, 2001, 29, 2, 2001, 1));
		// year boundary
		directed.push_back(query(31, 12, 1999, 1, 1, 2000, 0));
		directed.push_back(query(1, 1, 9999, 31, 12, 9999, 1));
		// dates that do not exist
		directed.push_back(query(0, 5, 2010, 1, 6, 2010, 1));
		directed.push_back(query(1, 0, 2010, 1, 6, 2010, 0));
		directed.push_back(query(1, 13, 2010, 1, 6, 2010, 1));
		directed.push_back(query(1, 1, 2010, 1, 15, 2010, 1));
		directed.push_back(query(1, 1, 0, 1, 1, 5, 1));
		directed.push_back(query(1, 1, 5, 1, 1, 10000, 1));
		directed.push_back(query(1, 1, 5, 1, 1, 16383, 0));
		directed.push_back(query(31, 4, 2020, 31, 12, 2020, 1));
		directed.push_back(query(1, 1, 2020, 31, 11, 2020, 0));
		directed.push_back(query(31, 15, 16383, 31, 15, 16383, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer(directed[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// receiver holds off while items keep coming, so the input backs up
			if (n == 300 || n == 1200)
				hold_req++;
			// sender pause with the pipeline fully drained
			if (n == 800)
				drain();
			// final stretch runs at full rate
			if (n == RANDOM_ITEMS - 150)
				quiet = 1'b1;
			offer(random_query());
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("PASS date_difference_in_days");
		else
			$display("FAIL date_difference_in_days");
		$finish;
	end

endmodule
